// File: src/mhd_pkg.sv
// ----------------------------------------------------------------------------
// Masked Hamming distance package
// Sizes, count types and the status record shared by the distance block.
// ----------------------------------------------------------------------------
package mhd_pkg;

  // Descriptor geometry.
  localparam int DESC_BYTES = 64;
  localparam int LANE_BYTES = 8;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 64;
  localparam int DIST_W     = 10;

  // Count ranges that follow from the geometry.
  localparam int COUNT_MAX  = 8 * DESC_BYTES;
  localparam int CNT_W      = $clog2(COUNT_MAX + 1);
  localparam int LANE_CNT_W = $clog2(BYTE_W + 1);
  localparam int SUM_W      = $clog2(BYTE_W * LANE_BYTES + 1);

  // Divider widths. The quotient never exceeds COUNT_MAX, so CNT_W steps suffice.
  localparam int PROD_W     = 2 * CNT_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = CNT_W + 1;
  localparam int QUO_W      = CNT_W;
  localparam int STEP_W     = $clog2(QUO_W);

  // Counts found by one byte lane.
  typedef struct packed {
    logic [LANE_CNT_W-1:0] da;
    logic [LANE_CNT_W-1:0] db;
    logic [LANE_CNT_W-1:0] na;
    logic [LANE_CNT_W-1:0] nb;
    logic [LANE_CNT_W-1:0] pd;
  } lane_cnt_t;

  // Running counts of one descriptor pair.
  typedef struct packed {
    logic [CNT_W-1:0] da;
    logic [CNT_W-1:0] db;
    logic [CNT_W-1:0] na;
    logic [CNT_W-1:0] nb;
    logic [CNT_W-1:0] pd;
  } counts_t;

  // Divider status toward the top level.
  typedef struct packed {
    logic              idle;
    logic              done;
    logic [DIST_W-1:0] distance;
  } div_stat_t;

endpackage

// File: src/mhd_stream_if.sv
// ----------------------------------------------------------------------------
// Masked Hamming distance channels
// Valid/ready channels for descriptor words and for distance results.
// ----------------------------------------------------------------------------
interface mhd_desc_if;
  import mhd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] a_bits;
  logic [WORD_W-1:0] a_mask;
  logic [WORD_W-1:0] b_bits;
  logic [WORD_W-1:0] b_mask;
  logic              last_word;

  modport source (output valid, a_bits, a_mask, b_bits, b_mask, last_word, input ready);
  modport sink (input valid, a_bits, a_mask, b_bits, b_mask, last_word, output ready);
endinterface

interface mhd_dist_if;
  import mhd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

// File: src/mhd_lane.sv
// ----------------------------------------------------------------------------
// Masked Hamming distance byte lane
// Counts the differing bits, the mask bits and the masked differing bits of one byte.
// ----------------------------------------------------------------------------
module mhd_lane (
  input  logic [mhd_pkg::BYTE_W-1:0] a_bits,
  input  logic [mhd_pkg::BYTE_W-1:0] a_mask,
  input  logic [mhd_pkg::BYTE_W-1:0] b_bits,
  input  logic [mhd_pkg::BYTE_W-1:0] b_mask,
  output mhd_pkg::lane_cnt_t         cnt
);
  import mhd_pkg::*;

  logic [BYTE_W-1:0] diff;

  function automatic logic [LANE_CNT_W-1:0] ones(input logic [BYTE_W-1:0] v);
    logic [LANE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + LANE_CNT_W'(v[i]);
    end
    return n;
  endfunction

  // The five per-byte counts.
  always_comb begin
    diff   = a_bits ^ b_bits;
    cnt.da = ones(diff & a_mask);
    cnt.db = ones(diff & b_mask);
    cnt.na = ones(a_mask);
    cnt.nb = ones(b_mask);
    cnt.pd = ones(diff);
  end

endmodule

// File: src/mhd_merge.sv
// ----------------------------------------------------------------------------
// Masked Hamming distance merge and accumulate
// Adds the lane counts of a word and keeps the saturating running counts.
// ----------------------------------------------------------------------------
module mhd_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                last,
  input  mhd_pkg::lane_cnt_t  lane_cnt [mhd_pkg::LANE_BYTES],
  output mhd_pkg::counts_t    total
);
  import mhd_pkg::*;

  counts_t          acc;
  logic [SUM_W-1:0] word_da;
  logic [SUM_W-1:0] word_db;
  logic [SUM_W-1:0] word_na;
  logic [SUM_W-1:0] word_nb;
  logic [SUM_W-1:0] word_pd;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [SUM_W-1:0] inc);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(inc);
    return (s > (CNT_W+1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : s[CNT_W-1:0];
  endfunction

  // Word totals across the lanes.
  always_comb begin
    word_da = '0;
    word_db = '0;
    word_na = '0;
    word_nb = '0;
    word_pd = '0;
    for (int i = 0; i < LANE_BYTES; i++) begin
      word_da = word_da + SUM_W'(lane_cnt[i].da);
      word_db = word_db + SUM_W'(lane_cnt[i].db);
      word_na = word_na + SUM_W'(lane_cnt[i].na);
      word_nb = word_nb + SUM_W'(lane_cnt[i].nb);
      word_pd = word_pd + SUM_W'(lane_cnt[i].pd);
    end
  end

  // Running counts including the present word.
  always_comb begin
    total.da = sat_add(acc.da, word_da);
    total.db = sat_add(acc.db, word_db);
    total.na = sat_add(acc.na, word_na);
    total.nb = sat_add(acc.nb, word_nb);
    total.pd = sat_add(acc.pd, word_pd);
  end

  // The last word hands its totals on and starts the next pair from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= last ? '0 : total;
    end
  end

`ifndef NO_ASSERTIONS
  // A masked difference count can never pass its own mask count.
  a_acc_order: assert property (@(posedge clk) disable iff (rst)
    acc.da <= acc.na && acc.db <= acc.nb && acc.pd <= CNT_W'(COUNT_MAX))
    else $error("mhd_merge: running counts out of order");
`endif

endmodule

// File: src/mhd_div.sv
// ----------------------------------------------------------------------------
// Masked Hamming distance weighting unit; plain mode passes pd on unchanged.
// Forms dA*nA + dB*nB and nA + nB, then divides one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mhd_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                use_masks,
  input  mhd_pkg::counts_t    cnt,
  input  logic                take,
  output mhd_pkg::div_stat_t  stat
);
  import mhd_pkg::*;

  typedef enum logic [2:0] {IDLE, MUL, SUM, DIV, DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  da;
  logic [CNT_W-1:0]  db;
  logic [CNT_W-1:0]  na;
  logic [CNT_W-1:0]  nb;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  qs;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  num;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Numerator sum and one restoring division step.
  always_comb begin
    num   = NUM_W'(prod_a) + NUM_W'(prod_b);
    trial = {rem, qs[QUO_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  // Sequencer with its data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            if (use_masks) begin
              da    <= cnt.da;
              db    <= cnt.db;
              na    <= cnt.na;
              nb    <= cnt.nb;
              state <= MUL;
            end else begin
              qs    <= cnt.pd;
              state <= DONE;
            end
          end
        end
        MUL: begin
          prod_a <= PROD_W'(da) * PROD_W'(na);
          prod_b <= PROD_W'(db) * PROD_W'(nb);
          den    <= DEN_W'(na) + DEN_W'(nb);
          state  <= SUM;
        end
        SUM: begin
          rem  <= num[NUM_W-1 -: DEN_W];
          step <= STEP_W'(QUO_W - 1);
          if (den == '0) begin
            // Both masks empty: the distance is zero.
            qs    <= '0;
            state <= DONE;
          end else begin
            qs    <= num[QUO_W-1:0];
            state <= DIV;
          end
        end
        DIV: begin
          rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          qs  <= {qs[QUO_W-2:0], ge};
          if (step == '0) begin
            state <= DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        DONE: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign stat.idle     = (state == IDLE);
  assign stat.done     = (state == DONE);
  assign stat.distance = DIST_W'(qs);

`ifndef NO_ASSERTIONS
  // The partial remainder stays below the divisor through every step.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == DIV |-> rem < den)
    else $error("mhd_div: remainder not below divisor");

  // The plain distance needs no arithmetic and is ready in the next cycle.
  a_plain_fast: assert property (@(posedge clk) disable iff (rst)
    state == IDLE && start && !use_masks |=> state == DONE)
    else $error("mhd_div: plain distance delayed");

  // A weighted average of counts cannot exceed the largest count.
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    state == DONE |-> qs <= QUO_W'(COUNT_MAX))
    else $error("mhd_div: quotient out of range");
`endif

endmodule

// File: src/masked_hamming_distance.sv
// A result is registered at the output once the divider is done; in masked mode
// the divider first steps through MUL, SUM and DIV, the last bit-serially.
// Throughput: one non-last word per cycle while the divider is idle; the last word
// occupies the divider, and no word is taken until its result has been handed on.
// Reset (rst, synchronous): counts clear, divider goes idle, use_masks is 1.
// ----------------------------------------------------------------------------
// Masked Hamming distance top level
// Byte lanes count each word, a merge stage accumulates, a divider weights.
// ----------------------------------------------------------------------------
module masked_hamming_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  mhd_desc_if.sink           desc,
  mhd_dist_if.source         result
);
  import mhd_pkg::*;

  logic       use_masks;
  logic       accept;
  logic       start;
  logic       take;
  lane_cnt_t  lane_cnt [LANE_BYTES];
  counts_t    total;
  div_stat_t  stat;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_masks <= 1'b1;
    end else if (cfg_we) begin
      use_masks <= cfg_data;
    end
  end

  // Words are taken whenever the divider is free.
  assign desc.ready = stat.idle;
  assign accept     = desc.valid && desc.ready;
  assign start      = accept && desc.last_word;

  // One lane per byte of the word.
  for (genvar i = 0; i < LANE_BYTES; i++) begin : g_lane
    mhd_lane u_lane (
      .a_bits (desc.a_bits[BYTE_W*i +: BYTE_W]),
      .a_mask (desc.a_mask[BYTE_W*i +: BYTE_W]),
      .b_bits (desc.b_bits[BYTE_W*i +: BYTE_W]),
      .b_mask (desc.b_mask[BYTE_W*i +: BYTE_W]),
      .cnt    (lane_cnt[i])
    );
  end

  mhd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .last     (desc.last_word),
    .lane_cnt (lane_cnt),
    .total    (total)
  );

  mhd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .use_masks (use_masks),
    .cnt       (total),
    .take      (take),
    .stat      (stat)
  );

  // Output register between the divider and the result channel.
  assign take = stat.done && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.distance <= stat.distance;
    end
  end

`ifndef NO_ASSERTIONS
  // A last word occupies the divider, so no further word is taken at once.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    start |=> !desc.ready)
    else $error("masked_hamming_distance: word taken while dividing");
`endif

endmodule

// File: tb/sv/tb_masked_hamming_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked Hamming distance testbench
// Feeds descriptor word pairs through the valid/ready input channel, with the
// mode register switched between phases. A directed table comes first, then
// random pairs, some with a missing last word. Each distance is compared
// against an in-bench model of the five running counts and the weighted
// divide. Both channels idle at random outside one stretch with no idling.
// ----------------------------------------------------------------------------
module tb_masked_hamming_distance;
  import mhd_pkg::*;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [CNT_W-1:0]  count_t;

  // One descriptor word as it is moved by the input channel.
  typedef struct packed {
    logic [WORD_W-1:0] a_bits;
    logic [WORD_W-1:0] a_mask;
    logic [WORD_W-1:0] b_bits;
    logic [WORD_W-1:0] b_mask;
    logic              last_word;
  } desc_word_t;

  // One row of the directed table.
  typedef struct {
    bit         set_mode;
    bit         mode;
    desc_word_t w;
    bit         known;
    dist_t      known_dist;
  } desc_row_t;

  localparam bit                MODE_PLAIN    = 1'b0;
  localparam bit                MODE_MASKED   = 1'b1;
  localparam logic [WORD_W-1:0] ONES          = '1;
  localparam logic [WORD_W-1:0] ZERO          = '0;
  localparam int                RANDOM_ITEMS  = 1550;
  localparam int                SETTLE_CYCLES = CNT_W + 10;
  localparam int                TIMEOUT_NS    = 20_000_000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  mhd_desc_if desc_ch ();
  mhd_dist_if dist_ch ();

  masked_hamming_distance i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .desc     (desc_ch),
    .result   (dist_ch)
  );

  // Model state: the running counts of the current pair and the mode.
  count_t run_da, run_db, run_na, run_nb, run_pd;
  bit     mode_masked;

  dist_t      expected_dist[$];
  desc_row_t  directed_rows[$];
  int         fail_count;
  int         items_sent;
  bit         steady_run;

  // Clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic count_t sat_add(input count_t acc, input int unsigned inc);
    int unsigned s;
    s = acc + inc;
    return (s > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(s);
  endfunction

  // Adds one word to the running counts; on the last word it returns 1 with
  // the distance of the pair and clears the counts.
  function automatic bit accumulate_word(input desc_word_t w, output dist_t dist_out);
    logic [WORD_W-1:0] x;
    int unsigned       num;
    int unsigned       den;
    int unsigned       quo;
    x      = w.a_bits ^ w.b_bits;
    run_da = sat_add(run_da, $countones(x & w.a_mask));
    run_db = sat_add(run_db, $countones(x & w.b_mask));
    run_na = sat_add(run_na, $countones(w.a_mask));
    run_nb = sat_add(run_nb, $countones(w.b_mask));
    run_pd = sat_add(run_pd, $countones(x));
    dist_out = '0;
    if (!w.last_word) return 1'b0;
    if (mode_masked) begin
      den = run_na + run_nb;
      num = run_da * run_na + run_db * run_nb;
      quo = (den == 0) ? 0 : num / den;
    end else begin
      quo = run_pd;
    end
    dist_out = quo[DIST_W-1:0];
    run_da = '0;
    run_db = '0;
    run_na = '0;
    run_nb = '0;
    run_pd = '0;
    return 1'b1;
  endfunction

  // Random 64-bit word with a bias toward empty, full and sparse patterns.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] r1;
    logic [WORD_W-1:0] r2;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return ZERO;
      1: return ONES;
      2: return r1 & r2 & {$urandom, $urandom};
      3: return r1 | r2;
      default: return r1;
    endcase
  endfunction

  function automatic desc_word_t rand_desc_word(input bit last);
    desc_word_t w;
    w.a_bits = rand_word();
    w.a_mask = rand_word();
    w.b_mask = rand_word();
    case ($urandom_range(0, 4))
      0: w.b_bits = w.a_bits;
      1: w.b_bits = ~w.a_bits;
      2: w.b_bits = w.a_bits ^ (rand_word() & rand_word());
      default: w.b_bits = rand_word();
    endcase
    w.last_word = last;
    return w;
  endfunction

  task automatic add_row(input bit set_mode, input bit mode, input logic [WORD_W-1:0] a,
                         input logic [WORD_W-1:0] am, input logic [WORD_W-1:0] b,
                         input logic [WORD_W-1:0] bm, input bit last, input bit known,
                         input dist_t known_dist);
    desc_row_t row;
    row.set_mode   = set_mode;
    row.mode       = mode;
    row.w          = '{a_bits: a, a_mask: am, b_bits: b, b_mask: bm, last_word: last};
    row.known      = known;
    row.known_dist = known_dist;
    directed_rows.push_back(row);
  endtask

  // Offers one item, with random gaps before it, and books its result once
  // it has been accepted. A known distance replaces the model's value.
  task automatic push_word(input desc_word_t w, input bit known, input dist_t known_dist);
    dist_t d;
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 11) begin
        desc_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    desc_ch.valid     <= 1'b1;
    desc_ch.a_bits    <= w.a_bits;
    desc_ch.a_mask    <= w.a_mask;
    desc_ch.b_bits    <= w.b_bits;
    desc_ch.b_mask    <= w.b_mask;
    desc_ch.last_word <= w.last_word;
    @(posedge clk);
    while (!desc_ch.ready) @(posedge clk);
    items_sent++;
    if (accumulate_word(w, d)) expected_dist.push_back(known ? known_dist : d);
  endtask

  // Waits until the block has drained, then writes the mode register.
  task automatic write_mode(input bit mode);
    desc_ch.valid <= 1'b0;
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mode_masked  = mode;
  endtask

  // Result side: random stalls, and the check of each accepted distance.
  always @(posedge clk) begin
    if (!rst && dist_ch.valid && dist_ch.ready) begin
      if (expected_dist.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected distance %0d", $time, dist_ch.distance);
      end else begin
        if (dist_ch.distance !== expected_dist[0]) begin
          fail_count++;
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, expected_dist[0], dist_ch.distance);
        end
        void'(expected_dist.pop_front());
      end
    end
    dist_ch.ready <= steady_run ? 1'b1 : ($urandom_range(0, 99) >= 11);
  end

  // Stimulus and end of run.
  initial begin
    desc_word_t w;
    int         phase;
    int         phase_end;
    int         pair_len;
    bit         drop_last;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_data          <= 1'b0;
    desc_ch.valid     <= 1'b0;
    desc_ch.a_bits    <= '0;
    desc_ch.a_mask    <= '0;
    desc_ch.b_bits    <= '0;
    desc_ch.b_mask    <= '0;
    desc_ch.last_word <= 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    steady_run  = 1'b0;
    mode_masked = MODE_MASKED;
    run_da = '0;
    run_db = '0;
    run_na = '0;
    run_nb = '0;
    run_pd = '0;

    // Masked mode out of reset: full masks, empty masks, one mask, no difference.
    add_row(0, MODE_MASKED, ONES, ONES, ZERO, ONES, 1, 1, 64);
    add_row(0, MODE_MASKED, ONES, ZERO, ZERO, ZERO, 1, 1, 0);
    add_row(0, MODE_MASKED, ONES, ONES, ZERO, ZERO, 1, 1, 64);
    add_row(0, MODE_MASKED, 64'hA5A5_5A5A_0FF0_C33C, ONES, 64'hA5A5_5A5A_0FF0_C33C, ONES,
            1, 1, 0);
    // Ten full-difference words: the counts saturate before the last word.
    repeat (9) add_row(0, MODE_MASKED, ONES, ONES, ZERO, ONES, 0, 0, 0);
    add_row(0, MODE_MASKED, ONES, ONES, ZERO, ONES, 1, 1, 512);
    // Plain mode.
    add_row(1, MODE_PLAIN, ONES, ZERO, ZERO, ZERO, 1, 1, 64);
    add_row(0, MODE_PLAIN, 64'h0F0F_0F0F_0F0F_0F0F, ONES, 64'hF0F0_F0F0_F0F0_00F0, ONES,
            1, 0, 0);
    // Mode changes in the middle of a pair, both ways.
    add_row(0, MODE_PLAIN, ONES, 64'h0000_0000_0000_00FF, ZERO, ONES, 0, 0, 0);
    add_row(1, MODE_MASKED, ZERO, ZERO, ZERO, ZERO, 1, 0, 0);
    add_row(0, MODE_MASKED, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_0000_FFFF_0000,
            64'h0FED_CBA9_8765_4321, 64'h00FF_00FF_F0F0_0F0F, 1, 0, 0);
    add_row(0, MODE_MASKED, ONES, 64'h8000_0000_0000_0001, ZERO, ZERO, 0, 0, 0);
    add_row(1, MODE_PLAIN, 64'h8000_0000_0000_0001, ONES, ZERO, ONES, 1, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mode) write_mode(directed_rows[i].mode);
      push_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].known_dist);
    end

    // Random phases of well-formed pairs, now and then with the last word
    // dropped so that a pair runs on into the next one, at times into a new mode.
    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      write_mode((phase % 2 == 0) ? MODE_PLAIN : MODE_MASKED);
      steady_run = (phase == 3);
      phase_end  = items_sent + $urandom_range(150, 300);
      if (phase_end > RANDOM_ITEMS) phase_end = RANDOM_ITEMS;
      while (items_sent < phase_end) begin
        pair_len  = ($urandom_range(0, 99) < 6) ? $urandom_range(9, 14)
                                                : $urandom_range(1, 8);
        drop_last = ($urandom_range(0, 99) < 5);
        for (int k = 0; k < pair_len; k++) begin
          w = rand_desc_word((k == pair_len - 1) && !drop_last);
          push_word(w, 1'b0, '0);
        end
      end
      phase++;
    end
    // Close any open pair so that its counts are checked too.
    push_word(rand_desc_word(1'b1), 1'b0, '0);
    steady_run = 1'b0;

    // Drain.
    desc_ch.valid <= 1'b0;
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** masked_hamming_distance: PASSED **");
    end else begin
      $display("** masked_hamming_distance: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("** masked_hamming_distance: FAILED **");
    $finish;
  end

endmodule
